// ===== hdl/rect_collision_table_top_defines.svh =====
// Assertion macros for the rectangle collision table.
// Depends on nothing; included by the modules that carry assertions.
// Macros take a label, clock, reset (RCT_ASSERT only), property and message.
`ifndef RECT_COLLISION_TABLE_TOP_DEFINES_SVH
`define RECT_COLLISION_TABLE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define RCT_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define RCT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RCT_ASSERT(lbl, clk, rst, prop, msg)
`define RCT_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== hdl/rct_pkg.sv =====
// Package for the rectangle collision table: sizes, command codes,
// payload structs and the scan state type. Depends on nothing.
package rct_pkg;

  // Table depth, the widths that follow from it, and the payload widths.
  localparam int MaxRects   = 64;
  localparam int IdxW       = (MaxRects > 1) ? $clog2(MaxRects) : 1;
  localparam int CntW       = $clog2(MaxRects + 1);
  localparam int EntryCntW  = 7;
  localparam int CoordW     = 16;
  localparam int SizeW      = 15;
  localparam int EdgeW      = CoordW + 1;

  typedef enum logic [1:0] {
    FUNC_ADD    = 2'd0,
    FUNC_CLEAR  = 2'd1,
    FUNC_QRECT  = 2'd2,
    FUNC_QPOINT = 2'd3
  } rct_func_t;

  typedef struct packed {
    rct_func_t                 func;
    logic signed [CoordW-1:0]  pos_x;
    logic signed [CoordW-1:0]  pos_y;
    logic        [SizeW-1:0]   size_w;
    logic        [SizeW-1:0]   size_h;
  } rct_req_t;

  typedef struct packed {
    logic                  hit;
    logic                  status;
    logic [EntryCntW-1:0]  entry_count;
  } rct_rsp_t;

  // One stored rectangle.
  typedef struct packed {
    logic signed [CoordW-1:0]  x;
    logic signed [CoordW-1:0]  y;
    logic        [SizeW-1:0]   w;
    logic        [SizeW-1:0]   h;
  } rct_rect_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } rct_state_t;

  // Far edge of a span: start plus length, one bit wider so it cannot wrap.
  function automatic logic signed [EdgeW-1:0] rct_edge(
    input logic signed [CoordW-1:0] pos,
    input logic        [SizeW-1:0]  len
  );
    logic signed [EdgeW-1:0] a;
    logic signed [EdgeW-1:0] b;
    a = EdgeW'(pos);
    b = $signed({{(EdgeW - SizeW){1'b0}}, len});
    return a + b;
  endfunction

endpackage

// ===== hdl/rect_collision_table_top.sv =====
// Rectangle collision table: stores rectangles and tests query
// rectangles or points against them. Uses rct_pkg and the defines header.
//
// Timing: an add or clear gives its result in the cycle after the transfer and
// leaves busy low, so such commands may follow each other every cycle. A
// query raises busy and walks the stored entries through the table memory's
// single read port, one entry per cycle, comparing each in one shared edge
// comparator; it ends on the first hit or once every stored entry has been
// compared, and its result is then registered onto rsp. The result is shown for
// exactly one cycle on rsp, marked by done; the receiver cannot stall it, so
// it must take every result in that cycle. The table needs no clearing pass
// after reset: only entries below the fill count are ever read.
`include "rect_collision_table_top_defines.svh"

module rect_collision_table_top (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  rct_pkg::rct_req_t req,
  output logic             done,
  output rct_pkg::rct_rsp_t rsp
);
  import rct_pkg::*;

  // Table memory and fill count.
  rct_rect_t        mem [MaxRects];
  logic [CntW-1:0]  count;
  logic [CntW-1:0]  count_next;

  // Scan state.
  rct_state_t       state;
  rct_state_t       state_next;
  rct_rect_t        query;
  logic [CntW-1:0]  rd_addr;
  logic [CntW-1:0]  rd_addr_next;
  logic             rd_vld;
  logic             rd_vld_next;
  rct_rect_t        rd_data;

  // Result register.
  logic             done_next;
  rct_rsp_t         rsp_next;

  // Decoded control.
  logic             accept;
  logic             is_query;
  logic             table_full;
  logic             wr_en;
  logic             rd_issue;
  logic             hit_now;
  logic             finish;

  assign accept     = start && !busy;
  assign is_query   = (req.func == FUNC_QRECT) || (req.func == FUNC_QPOINT);
  assign table_full = (count == CntW'(MaxRects));

  // Shared edge comparator: stored entry against the latched query.
  // A point query is a query rectangle of zero size, which gives exactly
  // the strict point test.
  logic signed [EdgeW-1:0] e_x0, e_y0, e_x1, e_y1;
  logic signed [EdgeW-1:0] q_x0, q_y0, q_x1, q_y1;

  always_comb begin
    e_x0 = EdgeW'(rd_data.x);
    e_y0 = EdgeW'(rd_data.y);
    e_x1 = rct_edge(rd_data.x, rd_data.w);
    e_y1 = rct_edge(rd_data.y, rd_data.h);
    q_x0 = EdgeW'(query.x);
    q_y0 = EdgeW'(query.y);
    q_x1 = rct_edge(query.x, query.w);
    q_y1 = rct_edge(query.y, query.h);
    hit_now = rd_vld && !((q_x0 >= e_x1) || (q_y0 >= e_y1) ||
                          (q_x1 <= e_x0) || (q_y1 <= e_y0));
  end

  // Scan ends on a hit, or once every issued read has been compared.
  assign finish = hit_now || (!rd_vld && (rd_addr == count));

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && is_query) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (finish) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs and datapath control.
  always_comb begin
    busy         = 1'b0;
    wr_en        = 1'b0;
    rd_issue     = 1'b0;
    count_next   = count;
    rd_addr_next = rd_addr;
    rd_vld_next  = 1'b0;
    done_next    = 1'b0;
    rsp_next     = rsp;
    case (state)
      ST_IDLE: begin
        rd_addr_next = '0;
        if (accept) begin
          rsp_next.hit         = 1'b0;
          rsp_next.status      = 1'b0;
          rsp_next.entry_count = EntryCntW'(count);
          case (req.func)
            FUNC_ADD: begin
              done_next = 1'b1;
              if (table_full) begin
                rsp_next.status = 1'b1;
              end else begin
                wr_en                = 1'b1;
                count_next           = count + 1'b1;
                rsp_next.entry_count = EntryCntW'(count + 1'b1);
              end
            end
            FUNC_CLEAR: begin
              done_next            = 1'b1;
              count_next           = '0;
              rsp_next.entry_count = '0;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        busy = 1'b1;
        if (finish) begin
          done_next            = 1'b1;
          rsp_next.hit         = hit_now;
          rsp_next.status      = 1'b0;
          rsp_next.entry_count = EntryCntW'(count);
        end else if (rd_addr != count) begin
          rd_issue     = 1'b1;
          rd_vld_next  = 1'b1;
          rd_addr_next = rd_addr + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      count   <= '0;
      rd_addr <= '0;
      rd_vld  <= 1'b0;
      done    <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      rd_addr <= rd_addr_next;
      rd_vld  <= rd_vld_next;
      done    <= done_next;
    end
  end

  // Payload registers: result and latched query. A point query is held
  // with zero size.
  always_ff @(posedge clk) begin
    rsp <= rsp_next;
    if (accept && is_query) begin
      query.x <= req.pos_x;
      query.y <= req.pos_y;
      if (req.func == FUNC_QPOINT) begin
        query.w <= '0;
        query.h <= '0;
      end else begin
        query.w <= req.size_w;
        query.h <= req.size_h;
      end
    end
  end

  // Table memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count[IdxW-1:0]] <= '{x: req.pos_x, y: req.pos_y,
                                w: req.size_w, h: req.size_h};
    end
    if (rd_issue) begin
      rd_data <= mem[rd_addr[IdxW-1:0]];
    end
  end

  // Checks on the scan and the fill count.
  `RCT_ASSERT(a_count_bound, clk, rst, (count <= CntW'(MaxRects)), "fill count above depth")
  `RCT_ASSERT(a_rd_in_scan, clk, rst, (rd_vld |-> (state == ST_SCAN)), "read data outside scan")
  `RCT_ASSERT(a_rd_addr_bound, clk, rst, ((state == ST_SCAN) |-> (rd_addr <= count)), "scan past fill count")
  `RCT_ASSERT(a_accept_progress, clk, rst, ((start && !busy) |=> (done || busy)), "transfer gave no result and no scan")
  `RCT_ASSERT(a_drop_when_full, clk, rst, ((done && rsp.status) |-> (count == CntW'(MaxRects))), "add dropped while table not full")

endmodule
